### rtl/wheel_speed_from_hall_pulses_unit_macros.svh
// Assertion macros shared by the wheel speed unit checkers.
`ifndef WHEEL_SPEED_FROM_HALL_PULSES_UNIT_MACROS_SVH
`define WHEEL_SPEED_FROM_HALL_PULSES_UNIT_MACROS_SVH

// Property checked outside reset only.
`define WSHP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked at every edge, reset included.
`define WSHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/wshp_pkg.sv
// Shared types and constants of the wheel speed unit.
`timescale 1ns / 1ps

package wshp_pkg;

    localparam int SAMPLE_BITS       = 10;
    localparam int COUNTER_BITS_DEF  = 16;
    localparam int NUMER_BITS        = 24;
    localparam int CODE_BITS         = 8;
    localparam int CFG_DATA_BITS     = 24;
    localparam int CFG_INDEX_BITS    = 2;

    localparam int RISE_RST          = 800;
    localparam int FALL_RST          = 700;
    localparam int PRELOAD_RST       = 55671;
    localparam int NUMER_RST         = 197063;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RISE    = 2'd0,
        CFG_FALL    = 2'd1,
        CFG_PRELOAD = 2'd2,
        CFG_NUMER   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                   operation;
        logic [SAMPLE_BITS-1:0] sample;
    } wshp_in_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] speed_code;
        logic                 timed_out;
    } wshp_out_t;

endpackage

### rtl/wheel_speed_from_hall_pulses_unit.sv
// Top level of the wheel speed unit: pass detector, tick counter, serial divider.
`timescale 1ns / 1ps

// Wheel speed from Hall pulses. Each input word is either an ADC sample of the
// Hall sensor (operation 0) or one timer tick (operation 1). A hysteresis
// detector turns samples into magnet passes: a pass fires when the detector is
// armed and the sample is at or above rise_threshold, and the detector re-arms
// at or below fall_threshold. Passes pair up: the first loads timer_preload
// into the up-counter, the second takes the elapsed ticks (counter minus
// preload, modulo the counter width) and returns speed_numerator / ticks as a
// UQ6.2 mph code, saturated at 255; zero elapsed ticks gives 255. A tick at the
// counter's maximum wraps it to zero, restarts the pairing and returns a
// timeout word (code 0, timed_out 1). A tick, a sample and a second pass with
// zero elapsed ticks are handled as they are accepted. A second pass with a
// non-zero count runs the restoring divider, which retires one quotient bit
// per cycle across all NUMER_BITS (24) dividend bits; no new word is taken
// while it runs. One output register plus one holding register absorb a
// stalled result side: input is taken while a result waits, and stops only
// when both are full. Configuration writes land at once and are meant for
// when the unit is idle.
module wheel_speed_from_hall_pulses_unit
    import wshp_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // sample / tick words
    input  logic                      s_valid,
    output logic                      s_ready,
    input  wshp_in_t                  s_data,
    // speed results
    output logic                      m_valid,
    input  logic                      m_ready,
    output wshp_out_t                 m_data,
    // register writes
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

    localparam int STEP_BITS = $clog2(NUMER_BITS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    // configuration
    logic [SAMPLE_BITS-1:0]  rise_reg;
    logic [SAMPLE_BITS-1:0]  fall_reg;
    logic [COUNTER_BITS-1:0] preload_reg;
    logic [NUMER_BITS-1:0]   numer_reg;

    // detector and pairing state
    state_t                  state_reg, state_next;
    logic                    above_reg, above_next;
    logic                    awaiting_reg, awaiting_next;
    logic [COUNTER_BITS-1:0] count_reg, count_next;

    // serial divider: dividend shifts out MSB first, quotient shifts in
    logic [COUNTER_BITS-1:0] dvsr_reg, dvsr_next;
    logic [NUMER_BITS-1:0]   dvnd_reg, dvnd_next;
    logic [COUNTER_BITS-1:0] rem_reg, rem_next;
    logic [CODE_BITS-1:0]    quo_reg, quo_next;
    logic                    sat_reg, sat_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;

    // result registers
    wshp_out_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    wshp_out_t               hold_reg, hold_next;
    logic                    hold_valid_reg, hold_valid_next;

    logic                    in_fire;
    logic                    out_free;
    logic                    emit_valid;
    wshp_out_t               emit_data;
    logic [COUNTER_BITS:0]   trial;
    logic [COUNTER_BITS:0]   diff;
    logic                    fits;
    logic [COUNTER_BITS-1:0] rem_step;
    logic [CODE_BITS-1:0]    quo_step;
    logic                    sat_step;
    logic [COUNTER_BITS-1:0] elapsed;

    assign s_ready  = (state_reg == ST_IDLE) && !hold_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;

    // Elapsed ticks wrap modulo the counter width.
    assign elapsed = count_reg - preload_reg;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg, dvnd_reg[NUMER_BITS-1]};
    assign fits     = trial >= {1'b0, dvsr_reg};
    assign diff     = trial - {1'b0, dvsr_reg};
    assign rem_step = fits ? diff[COUNTER_BITS-1:0] : trial[COUNTER_BITS-1:0];
    assign quo_step = {quo_reg[CODE_BITS-2:0], fits};
    // Any quotient bit pushed past the code width means saturation.
    assign sat_step = sat_reg | quo_reg[CODE_BITS-1];

    always_comb begin
        state_next    = state_reg;
        above_next    = above_reg;
        awaiting_next = awaiting_reg;
        count_next    = count_reg;
        dvsr_next     = dvsr_reg;
        dvnd_next     = dvnd_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        sat_next      = sat_reg;
        step_next     = step_reg;
        emit_valid    = 1'b0;
        emit_data     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.operation == OP_TICK) begin
                        if (&count_reg) begin
                            // wrap: timeout word, drop any pairing
                            count_next           = '0;
                            awaiting_next        = 1'b0;
                            emit_valid           = 1'b1;
                            emit_data.speed_code = '0;
                            emit_data.timed_out  = 1'b1;
                        end else begin
                            count_next = count_reg + COUNTER_BITS'(1);
                        end
                    end else if (!above_reg) begin
                        if (s_data.sample >= rise_reg) begin
                            above_next = 1'b1;
                            count_next = preload_reg;
                            if (!awaiting_reg) begin
                                awaiting_next = 1'b1;
                            end else begin
                                awaiting_next = 1'b0;
                                if (elapsed == '0) begin
                                    emit_valid           = 1'b1;
                                    emit_data.speed_code = CODE_MAX;
                                    emit_data.timed_out  = 1'b0;
                                end else begin
                                    // start the divide
                                    state_next = ST_DIV;
                                    dvsr_next  = elapsed;
                                    dvnd_next  = numer_reg;
                                    rem_next   = '0;
                                    quo_next   = '0;
                                    sat_next   = 1'b0;
                                    step_next  = STEP_BITS'(NUMER_BITS - 1);
                                end
                            end
                        end
                    end else if (s_data.sample <= fall_reg) begin
                        // re-arm; reload the counter when no pair is open
                        above_next = 1'b0;
                        if (!awaiting_reg) begin
                            count_next = preload_reg;
                        end
                    end
                end
            end
            ST_DIV: begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                sat_next  = sat_step;
                dvnd_next = {dvnd_reg[NUMER_BITS-2:0], 1'b0};
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == '0) begin
                    state_next           = ST_IDLE;
                    emit_valid           = 1'b1;
                    emit_data.speed_code = sat_step ? CODE_MAX : quo_step;
                    emit_data.timed_out  = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register first, holding register behind it when the sink stalls.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (out_free) begin
            if (hold_valid_reg) begin
                out_next        = hold_reg;
                out_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end else if (emit_valid) begin
                out_next       = emit_data;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (emit_valid) begin
            hold_next       = emit_data;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg    <= SAMPLE_BITS'(RISE_RST);
            fall_reg    <= SAMPLE_BITS'(FALL_RST);
            preload_reg <= COUNTER_BITS'(PRELOAD_RST);
            numer_reg   <= NUMER_BITS'(NUMER_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RISE:    rise_reg    <= cfg_wr_data[SAMPLE_BITS-1:0];
                CFG_FALL:    fall_reg    <= cfg_wr_data[SAMPLE_BITS-1:0];
                CFG_PRELOAD: preload_reg <= cfg_wr_data[COUNTER_BITS-1:0];
                CFG_NUMER:   numer_reg   <= cfg_wr_data[NUMER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            above_reg      <= 1'b0;
            awaiting_reg   <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            above_reg      <= above_next;
            awaiting_reg   <= awaiting_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvsr_reg <= dvsr_next;
        dvnd_reg <= dvnd_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        step_reg <= step_next;
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

endmodule

### rtl/wshp_checker.sv
// Port-level checker for the wheel speed unit, bound to the top level.
`timescale 1ns / 1ps
`include "wheel_speed_from_hall_pulses_unit_macros.svh"

module wshp_checker
    import wshp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input wshp_out_t m_data
);

    `WSHP_ASSERT(a_out_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed or vanished while stalled")

    `WSHP_ASSERT(a_ready_falls_on_accept, aclk, aresetn, $fell(s_ready) |-> $past(s_valid && s_ready), "input ready fell without an accepted word")

    `WSHP_ASSERT(a_timeout_is_zero, aclk, aresetn, m_valid && m_data.timed_out |-> m_data.speed_code == '0, "timeout word carries a non-zero speed")

    `WSHP_ASSERT_ALWAYS(a_reset_clean, aclk, !aresetn |=> !m_valid && s_ready, "unit not idle and empty after reset")

endmodule

bind wheel_speed_from_hall_pulses_unit wshp_checker u_wshp_checker (.*);

### tb/tb_wheel_speed_from_hall_pulses_unit.sv
// Self-checking bench for the wheel speed unit: directed and random words checked against a tachometer model.
`timescale 1ns / 1ps

module tb_wheel_speed_from_hall_pulses_unit;
    import wshp_pkg::*;

    localparam int          STALL_LIMIT   = 2000;  // cycles with no word moved and no register written
    localparam int          SETTLE_CYCLES = 30;    // divider run plus margin
    localparam int          PHASE_WORDS   = 105;
    localparam int          PHASE_SPEEDS  = 12;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    wshp_in_t                  s_data      = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    wshp_out_t                 m_data;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data = '0;

    // Tachometer model: register copies and detector / counter state.
    logic [SAMPLE_BITS-1:0] rise_lvl    = SAMPLE_BITS'(RISE_RST);
    logic [SAMPLE_BITS-1:0] fall_lvl    = SAMPLE_BITS'(FALL_RST);
    logic [15:0]            preload_val = 16'(PRELOAD_RST);
    logic [NUMER_BITS-1:0]  numer_val   = NUMER_BITS'(NUMER_RST);
    logic                   level_high  = 1'b0;
    logic                   pair_open   = 1'b0;
    logic [15:0]            tick_count  = '0;

    wshp_out_t speeds_due[$];
    int        n_words_sent    = 0;
    int        n_speeds_queued = 0;
    int        n_bad           = 0;
    int        stall_cycles    = 0;
    bit        calm            = 1'b0;  // no idling on either side while set

    wheel_speed_from_hall_pulses_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Result side: stall about a third of the time, never while calm.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 32);
    end

    // Speed code for an elapsed tick count: zero ticks and large quotients clamp to the top.
    function automatic logic [CODE_BITS-1:0] code_from_ticks(input logic [15:0] ticks);
        logic [NUMER_BITS-1:0] quot;
        if (ticks == 0) begin
            return CODE_MAX;
        end
        quot = numer_val / ticks;
        return (quot > 255) ? CODE_MAX : quot[CODE_BITS-1:0];
    endfunction

    // Advance the model by one accepted word; queue the speed word it causes, if any.
    function automatic void advance_tacho(input wshp_in_t w);
        wshp_out_t r;
        r = '0;
        if (w.operation == OP_TICK) begin
            // A tick at full count wraps, abandons the pair and reports a timeout,
            // whether or not a pair is open. The sample field plays no part.
            if (tick_count == COUNT_MAX) begin
                tick_count = '0;
                pair_open  = 1'b0;
                r.timed_out = 1'b1;
                speeds_due.push_back(r);
                n_speeds_queued++;
            end else begin
                tick_count = tick_count + 1'b1;
            end
        end else if (!level_high) begin
            // Armed: only the rise threshold is looked at.
            if (w.sample >= rise_lvl) begin
                level_high = 1'b1;
                if (pair_open) begin
                    // Elapsed ticks wrap if the preload moved above the count.
                    r.speed_code = code_from_ticks(tick_count - preload_val);
                    speeds_due.push_back(r);
                    n_speeds_queued++;
                end
                pair_open  = !pair_open;
                tick_count = preload_val;
            end
        end else if (w.sample <= fall_lvl) begin
            // Raised: only the fall threshold re-arms; reload when no pair is open.
            level_high = 1'b0;
            if (!pair_open) begin
                tick_count = preload_val;
            end
        end
    endfunction

    function automatic void log_fault(input string what);
        n_bad++;
        if (n_bad <= 10) begin
            $display("%0t ns: speed word mismatch: %s", $time, what);
        end
    endfunction

    // Check every accepted speed word against the oldest one due.
    always @(posedge aclk) begin : check_speeds
        wshp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (speeds_due.size() == 0) begin
                log_fault($sformatf("none due, got code %0d timed_out %0b",
                                    m_data.speed_code, m_data.timed_out));
            end else begin
                want = speeds_due.pop_front();
                if (m_data.speed_code !== want.speed_code ||
                    m_data.timed_out !== want.timed_out) begin
                    log_fault($sformatf("code exp %0d got %0d, timed_out exp %0b got %0b",
                                        want.speed_code, m_data.speed_code,
                                        want.timed_out, m_data.timed_out));
                end
            end
        end
    end

    // Count cycles in which no word moves and no register is written.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    // Send one word. Valid stays high after acceptance so that back-to-back
    // words never lower and raise it in the same step; idling drops it.
    task automatic send_word(input logic op, input logic [SAMPLE_BITS-1:0] smp);
        wshp_in_t w;
        w.operation = op;
        w.sample    = smp;
        while (!calm && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_tacho(w);
        n_words_sent++;
    endtask

    // Ticks carry random sample bits, which the unit must ignore.
    task automatic send_ticks(input int n);
        repeat (n) send_word(OP_TICK, SAMPLE_BITS'($urandom));
    endtask

    // One magnet pass: a sample that trips the detector, some ticks, a sample that re-arms.
    task automatic pass_magnet(input int gap);
        send_word(OP_SAMPLE, SAMPLE_BITS'($urandom_range(1023, rise_lvl)));
        send_ticks(gap);
        send_word(OP_SAMPLE, SAMPLE_BITS'($urandom_range(fall_lvl, 0)));
    endtask

    // Drop valid, wait for every speed word due, then let the divider settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (speeds_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers on consecutive cycles, with the unit idle.
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] rise, fall, preload, numer);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_RISE;
        cfg_wr_data <= rise;
        rise_lvl     = rise[SAMPLE_BITS-1:0];
        @(posedge aclk);
        cfg_index   <= CFG_FALL;
        cfg_wr_data <= fall;
        fall_lvl     = fall[SAMPLE_BITS-1:0];
        @(posedge aclk);
        cfg_index   <= CFG_PRELOAD;
        cfg_wr_data <= preload;
        preload_val  = preload[15:0];
        @(posedge aclk);
        cfg_index   <= CFG_NUMER;
        cfg_wr_data <= numer;
        numer_val    = numer;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Reset thresholds hit exactly, plus samples that must not switch the detector.
    task automatic test_threshold_edges();
        send_word(OP_SAMPLE, 10'd799);
        send_word(OP_SAMPLE, 10'd800);
        send_word(OP_SAMPLE, 10'd701);
        send_word(OP_SAMPLE, 10'd1023);
        send_word(OP_SAMPLE, 10'd700);
        send_ticks(3);
        send_word(OP_SAMPLE, 10'd800);
    endtask

    // Second pass with no tick in between.
    task automatic test_zero_elapsed();
        send_word(OP_SAMPLE, 10'd700);
        send_word(OP_SAMPLE, 10'd1023);
        send_word(OP_SAMPLE, 10'd0);
        send_word(OP_SAMPLE, 10'd900);
    endtask

    // A quotient inside the code range.
    task automatic test_division();
        set_config(24'd800, 24'd700, 24'(PRELOAD_RST), 24'd1000);
        send_word(OP_SAMPLE, 10'd0);
        pass_magnet(5);
        send_word(OP_SAMPLE, 10'd1023);
    endtask

    // Counter wrap with and without a pair open; a tick with a high sample field.
    task automatic test_counter_wrap();
        set_config(24'd800, 24'd700, 24'hFFFF, 24'd1000);
        send_word(OP_SAMPLE, 10'd0);
        send_word(OP_TICK, 10'h3FF);
        send_word(OP_SAMPLE, 10'd1023);
        send_word(OP_TICK, 10'h000);
    endtask

    // Preload raised between the passes of a pair: elapsed ticks wrap.
    task automatic test_preload_rewrite();
        set_config(24'd800, 24'd700, 24'd100, 24'd1000);
        send_word(OP_SAMPLE, 10'd0);
        send_word(OP_SAMPLE, 10'd1023);
        send_ticks(2);
        set_config(24'd800, 24'd700, 24'd200, 24'd1000);
        send_word(OP_SAMPLE, 10'd0);
        send_word(OP_SAMPLE, 10'd1023);
    endtask

    // Mostly clean revolutions with random gaps; the rest noise and broken sequences.
    task automatic run_laps(input logic [CFG_DATA_BITS-1:0] rise, fall, preload, numer);
        int first_word;
        int first_speed;
        set_config(rise, fall, preload, numer);
        first_word  = n_words_sent;
        first_speed = n_speeds_queued;
        while ((n_words_sent - first_word < PHASE_WORDS ||
                n_speeds_queued - first_speed < PHASE_SPEEDS) &&
               n_words_sent - first_word < 4 * PHASE_WORDS) begin
            if ($urandom_range(0, 9) < 8) begin
                pass_magnet($urandom_range(0, 4));
                send_ticks($urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 3)) send_word(1'($urandom), SAMPLE_BITS'($urandom));
            end
            // Now and then hold the sender until every speed word is back.
            if ($urandom_range(0, 39) == 0) begin
                wait_idle();
            end
        end
    endtask

    task automatic test_random_traffic();
        run_laps(24'd800, 24'd700, 24'(PRELOAD_RST), 24'd900);
        // Every sample switches the detector; short wrap distance; smallest numerator.
        calm = 1'b1;
        run_laps(24'd0, 24'd1023, 24'd65530, 24'd1);
        calm = 1'b0;
        run_laps(24'd1023, 24'd0, 24'd0, 24'hFFFFFF);
        run_laps(24'd512, 24'd511, 24'd65500, 24'd2500);
        run_laps(24'($urandom_range(0, 1023)), 24'($urandom_range(0, 1023)),
                 24'($urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 40)
                                          : $urandom_range(0, 65535)),
                 24'($urandom_range(1, 6000)));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_threshold_edges();
        test_zero_elapsed();
        test_division();
        test_counter_wrap();
        test_preload_rewrite();
        test_random_traffic();
        wait_idle();
        if (n_bad == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
